/* src/swrm_pkg.sv */
// shared types and constants for the sliding window rate meter
package swrm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WIN_W  = 8;

  typedef struct packed {
    logic [DATA_W-1:0] now_seconds;
    logic [DATA_W-1:0] byte_count;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] bytes_this_second;
    logic [DATA_W-1:0] average_rate;
  } out_beat_t;

endpackage

/* src/swrm_ram.sv */
// generic single write port, single read port ram with registered read data
module swrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 181
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sliding_window_rate_meter_top.sv */
// sliding window byte rate meter: per-second buckets in a circular ram, serial sum and divide
//
// The meter keeps one 32-bit byte bucket for the current second and one for each of the
// MAX_WINDOW seconds before it, held in a circular ram with a head pointer, so a step of
// time moves the pointer instead of the data. One item is handled at a time: the time
// update reads and rewrites the head bucket for the same second, makes one ram write per
// second for a step of gap seconds within the window, and clears the flags and writes only
// the new head bucket when the history is dropped; then the window is summed with one ram
// read per cycle and the sum is divided by W with a restoring divider that makes one
// quotient bit per cycle. A finished result waits while the output is stalled. The input
// is stalled while an item is in flight; a finished result sits in the output register
// while the next beat is taken. Buckets are marked empty at reset by one flag per entry,
// so no clearing pass is needed. The window register is taken from the config port at any
// time; zero reads as one and values above MAX_WINDOW read as MAX_WINDOW.
module sliding_window_rate_meter_top #(
  parameter int unsigned MAX_WINDOW = 180
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  swrm_pkg::in_beat_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output swrm_pkg::out_beat_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swrm_pkg::WIN_W-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH = MAX_WINDOW + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = swrm_pkg::DATA_W + AW;
  localparam int unsigned DCW   = $clog2(SW + 1);
  localparam logic [AW:0]                  DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [AW-1:0]                LAST_A  = AW'(DEPTH - 1);
  localparam logic [swrm_pkg::WIN_W-1:0]   MAXW8   = swrm_pkg::WIN_W'(MAX_WINDOW);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SAME_RD = 3'd1;
  localparam logic [2:0] ST_SAME_WR = 3'd2;
  localparam logic [2:0] ST_SHIFT   = 3'd3;
  localparam logic [2:0] ST_SUM     = 3'd4;
  localparam logic [2:0] ST_DIV     = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    r = (a == LAST_A) ? '0 : a + AW'(1);
    return r;
  endfunction

  logic [2:0]                    state_q, state_d;
  logic [swrm_pkg::WIN_W-1:0]    win_q, win_d;
  logic [swrm_pkg::DATA_W-1:0]   newest_q, newest_d;
  logic [AW-1:0]                 head_q, head_d;
  logic [AW-1:0]                 ptr_q, ptr_d;
  logic [AW-1:0]                 cnt_q, cnt_d;
  logic [AW-1:0]                 w_q, w_d;
  logic [swrm_pkg::DATA_W-1:0]   b0_q, b0_d;
  logic [SW-1:0]                 acc_q, acc_d;
  logic [AW-1:0]                 rem_q, rem_d;
  logic [DCW-1:0]                div_cnt_q, div_cnt_d;
  logic                          pend_q, pend_d;
  logic                          vld_rd_q;
  logic [DEPTH-1:0]              vld_q, vld_d;
  logic                          out_valid_q, out_valid_d;
  swrm_pkg::out_beat_t           out_data_q, out_data_d;

  logic                          in_acc;
  logic [AW-1:0]                 w_eff;
  logic [swrm_pkg::DATA_W-1:0]   gap;
  logic [AW:0]                   nh_diff;
  logic [AW:0]                   nh_wrap;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [swrm_pkg::DATA_W-1:0]   ram_wdata;
  logic [swrm_pkg::DATA_W-1:0]   ram_rdata;
  logic [swrm_pkg::DATA_W-1:0]   rd_word;
  logic [swrm_pkg::DATA_W:0]     sat_sum;
  logic [swrm_pkg::DATA_W-1:0]   sat_val;
  logic [AW:0]                   div_try;
  logic                          div_bit;
  logic                          clr_all;

  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    if (win_q == '0) begin
      w_eff = AW'(1);
    end else if (win_q > MAXW8) begin
      w_eff = AW'(MAX_WINDOW);
    end else begin
      w_eff = AW'(win_q);
    end
  end

  assign gap     = in_data_i.now_seconds - newest_q;
  assign nh_diff = {1'b0, head_q} - {1'b0, gap[AW-1:0]};
  assign nh_wrap = nh_diff[AW] ? nh_diff + DEPTH_W : nh_diff;

  assign rd_word = vld_rd_q ? ram_rdata : '0;
  assign sat_sum = {1'b0, rd_word} + {1'b0, b0_q};
  assign sat_val = sat_sum[swrm_pkg::DATA_W] ? '1 : sat_sum[swrm_pkg::DATA_W-1:0];

  assign div_try = {rem_q, acc_q[SW-1]};
  assign div_bit = (div_try >= {1'b0, w_q});

  swrm_ram #(
    .WIDTH(swrm_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    newest_d    = newest_q;
    head_d      = head_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    w_d         = w_q;
    b0_d        = b0_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = '0;
    clr_all     = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      win_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          newest_d = in_data_i.now_seconds;
          w_d      = w_eff;
          b0_d     = in_data_i.byte_count;
          acc_d    = '0;
          if (gap == '0) begin
            ptr_d   = head_q;
            state_d = ST_SAME_RD;
          end else if (gap <= swrm_pkg::DATA_W'(w_eff)) begin
            head_d  = nh_wrap[AW-1:0];
            ptr_d   = nh_wrap[AW-1:0];
            cnt_d   = gap[AW-1:0];
            state_d = ST_SHIFT;
          end else begin
            clr_all   = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = head_q;
            ram_wdata = in_data_i.byte_count;
            ptr_d     = wrap_inc(head_q);
            cnt_d     = w_eff;
            state_d   = ST_SUM;
          end
        end
      end
      ST_SAME_RD: begin
        state_d = ST_SAME_WR;
      end
      ST_SAME_WR: begin
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = sat_val;
        b0_d      = sat_val;
        ptr_d     = wrap_inc(head_q);
        cnt_d     = w_q;
        state_d   = ST_SUM;
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = (ptr_q == head_q) ? b0_q : '0;
        ptr_d     = wrap_inc(ptr_q);
        cnt_d     = cnt_q - AW'(1);
        if (cnt_q == AW'(1)) begin
          ptr_d   = wrap_inc(head_q);
          cnt_d   = w_q;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (pend_q) begin
          acc_d = acc_q + SW'(rd_word);
        end
        if (cnt_q != '0) begin
          ptr_d  = wrap_inc(ptr_q);
          cnt_d  = cnt_q - AW'(1);
          pend_d = 1'b1;
        end else begin
          rem_d     = '0;
          div_cnt_d = DCW'(SW);
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d     = div_bit ? AW'(div_try - {1'b0, w_q}) : div_try[AW-1:0];
        acc_d     = {acc_q[SW-2:0], div_bit};
        div_cnt_d = div_cnt_q - DCW'(1);
        if (div_cnt_q == DCW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                  = 1'b1;
          out_data_d.bytes_this_second = b0_q;
          out_data_d.average_rate      = acc_q[swrm_pkg::DATA_W-1:0];
          state_d                      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    vld_d = vld_q;
    if (clr_all) begin
      vld_d = '0;
    end
    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= swrm_pkg::WIN_W'(1);
      newest_q    <= '0;
      head_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      w_q         <= AW'(1);
      div_cnt_q   <= '0;
      pend_q      <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      newest_q    <= newest_d;
      head_q      <= head_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      w_q         <= w_d;
      div_cnt_q   <= div_cnt_d;
      pend_q      <= pend_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q       <= b0_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    vld_rd_q   <= vld_q[ptr_q];
    out_data_q <= out_data_d;
  end

endmodule
